### hdl/fbbc_pkg.sv
// Package for the follow bang-bang controller.
// Holds the drive command codes, the register indexes and the fixed field widths.
// Depends on nothing.
package fbbc_pkg;

	localparam int DistW   = 16;
	localparam int AngleW  = 16;
	localparam int TimeW   = 32;
	localparam int FiltW   = 24;
	localparam int AlphaW  = 9;
	localparam int ThreshW = 15;
	localparam int HoldW   = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 16;

	typedef logic [1:0] cmd_t;

	localparam cmd_t DRV_HALT  = 2'd0;
	localparam cmd_t DRV_AHEAD = 2'd1;
	localparam cmd_t DRV_LEFT  = 2'd2;
	localparam cmd_t DRV_RIGHT = 2'd3;

	typedef logic [CfgIdxW-1:0] reg_idx_t;

	localparam reg_idx_t REG_FILTER_ALPHA      = 3'd0;
	localparam reg_idx_t REG_ENABLE_DISTANCE   = 3'd1;
	localparam reg_idx_t REG_MIN_DISTANCE      = 3'd2;
	localparam reg_idx_t REG_TURN_ON_ANGLE     = 3'd3;
	localparam reg_idx_t REG_TURN_OFF_ANGLE    = 3'd4;
	localparam reg_idx_t REG_TARGET_DISTANCE   = 3'd5;
	localparam reg_idx_t REG_DISTANCE_DEADZONE = 3'd6;
	localparam reg_idx_t REG_HOLD_MS           = 3'd7;

endpackage

### hdl/follow_bang_bang_controller_unit.sv
// Follow bang-bang controller: filters distance and angle, then picks a drive command.
// Input, filter and command registers in turn; one item per cycle unless out_ready stalls.
// Stage 1 holds the filter loop (one 10x25 multiply per filter), stage 2 the decision loop.
// Reset (arst_n, asynchronous, active low) empties the pipeline, restores the register
// defaults, clears the filters and the seeded flag, and sets the last command to stop.
// Depends on fbbc_pkg.
module follow_bang_bang_controller_unit
	import fbbc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [DistW-1:0]     distance_in,
	input  logic signed [AngleW-1:0]    angle_in,
	input  logic        [TimeW-1:0]     now_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic        [1:0]           drive_cmd,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic        [CfgIdxW-1:0]   cfg_index,
	input  logic        [CfgDatW-1:0]   cfg_data
);

	// Configuration registers.
	logic [AlphaW-1:0]  alpha_q;
	logic [ThreshW-1:0] enable_dist_q, min_dist_q, turn_on_q, turn_off_q, target_q, deadzone_q;
	logic [HoldW-1:0]   hold_q;

	// Controller state.
	logic                    seeded_q;
	logic signed [FiltW-1:0] dist_filt_q, ang_filt_q;
	cmd_t                    last_cmd_q;
	logic [TimeW-1:0]        last_change_q;

	// Pipeline registers.
	logic                     valid_s1, valid_s2;
	logic signed [DistW-1:0]  dist_s1;
	logic signed [AngleW-1:0] ang_s1;
	logic [TimeW-1:0]         now_s1, now_s2;
	logic                     pos_s2;
	logic signed [FiltW-1:0]  d_s2, a_s2;
	logic                     out_valid_q;
	cmd_t                     cmd_q;

	logic out_free, go2, s2_free, go1;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign go2       = valid_s2 && out_free;
	assign s2_free   = !valid_s2 || go2;
	assign go1       = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || go1;
	assign out_valid = out_valid_q;
	assign drive_cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q       <= AlphaW'(77);
			enable_dist_q <= ThreshW'(80);
			min_dist_q    <= ThreshW'(320);
			turn_on_q     <= ThreshW'(1920);
			turn_off_q    <= ThreshW'(1024);
			target_q      <= ThreshW'(800);
			deadzone_q    <= ThreshW'(160);
			hold_q        <= HoldW'(200);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FILTER_ALPHA:      alpha_q       <= cfg_data[AlphaW-1:0];
				REG_ENABLE_DISTANCE:   enable_dist_q <= cfg_data[ThreshW-1:0];
				REG_MIN_DISTANCE:      min_dist_q    <= cfg_data[ThreshW-1:0];
				REG_TURN_ON_ANGLE:     turn_on_q     <= cfg_data[ThreshW-1:0];
				REG_TURN_OFF_ANGLE:    turn_off_q    <= cfg_data[ThreshW-1:0];
				REG_TARGET_DISTANCE:   target_q      <= cfg_data[ThreshW-1:0];
				REG_DISTANCE_DEADZONE: deadzone_q    <= cfg_data[ThreshW-1:0];
				REG_HOLD_MS:           hold_q        <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	// Stage 0 to stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dist_s1 <= distance_in;
			ang_s1  <= angle_in;
			now_s1  <= now_ms;
		end
	end

	// Stage 1: exponential filters.
	logic                    pos_s1;
	logic signed [FiltW-1:0] dist_new, ang_new;

	function automatic logic signed [FiltW-1:0] ema_step(
		input logic signed [FiltW-1:0] f_in,
		input logic signed [15:0]      x,
		input logic                    seed,
		input logic [AlphaW-1:0]       alpha
	);
		logic signed [FiltW-1:0] x256, f;
		logic signed [FiltW:0]   diff;
		logic signed [34:0]      prod;
		logic signed [27:0]      sum;
		x256 = {x, 8'b0};
		f    = seed ? x256 : f_in;
		diff = {x256[FiltW-1], x256} - {f[FiltW-1], f};
		prod = $signed({1'b0, alpha}) * diff;
		// The arithmetic shift of the product gives the floored division by 256.
		sum  = {{4{f[FiltW-1]}}, f} + {prod[34], prod[34:8]};
		if (sum > 28'sd8388607) begin
			ema_step = 24'sh7FFFFF;
		end else if (sum < -28'sd8388608) begin
			ema_step = 24'sh800000;
		end else begin
			ema_step = sum[FiltW-1:0];
		end
	endfunction

	assign pos_s1   = !dist_s1[DistW-1] && (dist_s1 != '0);
	assign dist_new = ema_step(dist_filt_q, dist_s1, !seeded_q, alpha_q);
	assign ang_new  = ema_step(ang_filt_q, ang_s1, !seeded_q, alpha_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q    <= 1'b0;
			dist_filt_q <= '0;
			ang_filt_q  <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (go1 && pos_s1) begin
				seeded_q    <= 1'b1;
				dist_filt_q <= dist_new;
				ang_filt_q  <= ang_new;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			pos_s2 <= pos_s1;
			d_s2   <= dist_new;
			a_s2   <= ang_new;
			now_s2 <= now_s1;
		end
	end

	// Stage 2: decision with hysteresis and hold.
	logic signed [FiltW:0] d_ext, abs_a;
	logic signed [FiltW:0] enable_ext, min_ext, on_ext, off_ext, fwd_ext;
	logic [ThreshW:0]      fwd_sum;
	logic                  turning, too_close, was_turning, held;
	logic [TimeW-1:0]      elapsed;
	cmd_t                  want, cmd_next;

	always_comb begin
		d_ext      = {d_s2[FiltW-1], d_s2};
		abs_a      = a_s2[FiltW-1] ? -{a_s2[FiltW-1], a_s2} : {a_s2[FiltW-1], a_s2};
		enable_ext = $signed({2'b0, enable_dist_q, 8'b0});
		min_ext    = $signed({2'b0, min_dist_q, 8'b0});
		on_ext     = $signed({2'b0, turn_on_q, 8'b0});
		off_ext    = $signed({2'b0, turn_off_q, 8'b0});
		fwd_sum    = {1'b0, target_q} + {1'b0, deadzone_q};
		fwd_ext    = $signed({1'b0, fwd_sum, 8'b0});
		too_close  = (d_ext <= enable_ext) || (d_ext < min_ext);
		was_turning = (last_cmd_q == DRV_LEFT) || (last_cmd_q == DRV_RIGHT);
		turning    = was_turning ? (abs_a > off_ext) : (abs_a > on_ext);
		if (turning) begin
			want = a_s2[FiltW-1] ? DRV_LEFT : DRV_RIGHT;
		end else if (d_ext > fwd_ext) begin
			want = DRV_AHEAD;
		end else begin
			want = DRV_HALT;
		end
		elapsed = now_s2 - last_change_q;
		held    = (want != last_cmd_q) && (last_cmd_q != DRV_HALT) &&
		          (elapsed < {{(TimeW-HoldW){1'b0}}, hold_q});
		if (!pos_s2 || too_close) begin
			cmd_next = DRV_HALT;
		end else if (held) begin
			cmd_next = last_cmd_q;
		end else begin
			cmd_next = want;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q    <= DRV_HALT;
			last_change_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (go2) begin
				last_cmd_q <= cmd_next;
				// The change time moves only on the normal decision path.
				if (pos_s2 && !too_close && (cmd_next != last_cmd_q)) begin
					last_change_q <= now_s2;
				end
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go2) begin
			cmd_q <= cmd_next;
		end
	end

endmodule

### verif/follow_bang_bang_controller_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for follow_bang_bang_controller_unit: random traffic on all channels,
// drive commands checked against a cycle-free model of the filters, hysteresis and hold.
// Depends on fbbc_pkg and the controller RTL.
module follow_bang_bang_controller_unit_tb;
	import fbbc_pkg::*;

	localparam int IDLE_PCT       = 36;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam longint FILT_MAX   = 64'sd8388607;
	localparam longint FILT_MIN   = -64'sd8388608;

	typedef struct {
		logic signed [DistW-1:0]  distance;
		logic signed [AngleW-1:0] angle;
		logic        [TimeW-1:0]  stamp;
	} sensor_item_t;

	typedef struct {
		reg_idx_t           idx;
		logic [CfgDatW-1:0] data;
	} reg_write_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DistW-1:0]  distance_in = '0;
	logic signed [AngleW-1:0] angle_in = '0;
	logic        [TimeW-1:0]  now_ms = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic        [1:0]        drive_cmd;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic        [CfgIdxW-1:0] cfg_index = '0;
	logic        [CfgDatW-1:0] cfg_data = '0;

	follow_bang_bang_controller_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.distance_in (distance_in),
		.angle_in    (angle_in),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_cmd   (drive_cmd),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Register copies, at their reset values.
	logic [AlphaW-1:0]  alpha_reg    = 9'd77;
	logic [ThreshW-1:0] enable_reg   = 15'd80;
	logic [ThreshW-1:0] min_reg      = 15'd320;
	logic [ThreshW-1:0] turn_on_reg  = 15'd1920;
	logic [ThreshW-1:0] turn_off_reg = 15'd1024;
	logic [ThreshW-1:0] target_reg   = 15'd800;
	logic [ThreshW-1:0] deadzone_reg = 15'd160;
	logic [HoldW-1:0]   hold_reg     = 16'd200;

	// Controller state.
	bit          filters_seeded = 1'b0;
	longint      dist_filt = 0;
	longint      ang_filt = 0;
	cmd_t        last_cmd = DRV_HALT;
	logic [31:0] last_change = '0;

	sensor_item_t sensor_q[$];
	reg_write_t   reg_writes[$];
	cmd_t         expected_cmds[$];
	logic [CfgDatW-1:0] reg_plan [8];

	bit steady = 1'b0;
	int fail_count = 0;
	int items_sent = 0;
	int cmds_checked = 0;
	int writes_done = 0;
	int settings_used = 1;
	int cmd_seen [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;
	int walk_dist = 1200;
	int walk_ang = 0;
	logic [31:0] walk_clock = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint smooth_step(longint f, longint x);
		longint n;
		// The arithmetic shift gives the floor of the division by 256.
		n = f + ((longint'(alpha_reg) * (x * 256 - f)) >>> 8);
		if (n > FILT_MAX)
			n = FILT_MAX;
		if (n < FILT_MIN)
			n = FILT_MIN;
		return n;
	endfunction

	function automatic cmd_t next_drive_command(logic signed [DistW-1:0] range_val,
			logic signed [AngleW-1:0] ang, logic [TimeW-1:0] now);
		longint      mag;
		bit          turning;
		cmd_t        cmd;
		logic [31:0] elapsed;
		if (range_val <= 0) begin
			last_cmd = DRV_HALT;
			return DRV_HALT;
		end
		if (!filters_seeded) begin
			dist_filt = longint'(range_val) * 256;
			ang_filt = longint'(ang) * 256;
			filters_seeded = 1'b1;
		end
		dist_filt = smooth_step(dist_filt, longint'(range_val));
		ang_filt = smooth_step(ang_filt, longint'(ang));
		if (dist_filt <= longint'(enable_reg) * 256 || dist_filt < longint'(min_reg) * 256) begin
			last_cmd = DRV_HALT;
			return DRV_HALT;
		end
		mag = (ang_filt < 0) ? -ang_filt : ang_filt;
		if (last_cmd == DRV_LEFT || last_cmd == DRV_RIGHT)
			turning = mag > longint'(turn_off_reg) * 256;
		else
			turning = mag > longint'(turn_on_reg) * 256;
		if (turning)
			cmd = (ang_filt >= 0) ? DRV_RIGHT : DRV_LEFT;
		else if (dist_filt > (longint'(target_reg) + longint'(deadzone_reg)) * 256)
			cmd = DRV_AHEAD;
		else
			cmd = DRV_HALT;
		elapsed = now - last_change;
		// A running manoeuvre other than stop is kept until the hold time has passed.
		if (cmd != last_cmd && last_cmd != DRV_HALT && elapsed < {16'd0, hold_reg})
			cmd = last_cmd;
		if (cmd != last_cmd) begin
			last_cmd = cmd;
			last_change = now;
		end
		return cmd;
	endfunction

	function automatic void store_register(reg_idx_t idx, logic [CfgDatW-1:0] data);
		case (idx)
			REG_FILTER_ALPHA:      alpha_reg = data[AlphaW-1:0];
			REG_ENABLE_DISTANCE:   enable_reg = data[ThreshW-1:0];
			REG_MIN_DISTANCE:      min_reg = data[ThreshW-1:0];
			REG_TURN_ON_ANGLE:     turn_on_reg = data[ThreshW-1:0];
			REG_TURN_OFF_ANGLE:    turn_off_reg = data[ThreshW-1:0];
			REG_TARGET_DISTANCE:   target_reg = data[ThreshW-1:0];
			REG_DISTANCE_DEADZONE: deadzone_reg = data[ThreshW-1:0];
			REG_HOLD_MS:           hold_reg = data[HoldW-1:0];
			default: ;
		endcase
	endfunction

	// Sensor driver: the expectation is formed at the moment of the transfer.
	always @(posedge clk) begin : drive_sensor
		bit           offer;
		sensor_item_t item;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_cmds.push_back(next_drive_command(distance_in, angle_in, now_ms));
				items_sent++;
			end
			if (!in_valid || in_ready) begin
				offer = sensor_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT);
				if (offer) begin
					item = sensor_q.pop_front();
					distance_in <= item.distance;
					angle_in <= item.angle;
					now_ms <= item.stamp;
				end
				in_valid <= offer;
			end
		end
	end

	always @(posedge clk) begin : drive_registers
		bit         offer;
		reg_write_t wr;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				store_register(reg_idx_t'(cfg_index), cfg_data);
				writes_done++;
			end
			if (!cfg_valid || cfg_ready) begin
				offer = reg_writes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT);
				if (offer) begin
					wr = reg_writes.pop_front();
					cfg_index <= wr.idx;
					cfg_data <= wr.data;
				end
				cfg_valid <= offer;
			end
		end
	end

	always @(posedge clk) begin : check_commands
		cmd_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					$display("%0t: drive_cmd transfer with none expected: expected none, actual %0d",
						$time, drive_cmd);
					fail_count++;
				end else begin
					want = expected_cmds.pop_front();
					cmds_checked++;
					if (drive_cmd !== want) begin
						$display("%0t: drive_cmd mismatch: expected %0d, actual %0d",
							$time, want, drive_cmd);
						fail_count++;
					end else begin
						cmd_seen[drive_cmd]++;
					end
				end
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d commands outstanding",
					$time, quiet_cycles, expected_cmds.size());
				$display("follow_bang_bang_controller_unit_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic wait_idle();
		while (sensor_q.size() != 0 || in_valid || expected_cmds.size() != 0
				|| reg_writes.size() != 0 || cfg_valid)
			@(negedge clk);
		// Let the pipeline settle before the registers are touched.
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_reg_plan();
		wait_idle();
		for (int i = 0; i < 8; i++)
			reg_writes.push_back('{reg_idx_t'(i), reg_plan[i]});
		while (reg_writes.size() != 0 || cfg_valid)
			@(negedge clk);
		settings_used++;
	endtask

	task automatic plan_random_regs();
		int unsigned pick;
		int unsigned on_angle;
		pick = $urandom_range(9);
		if (pick == 0)
			reg_plan[REG_FILTER_ALPHA] = 16'd0;
		else if (pick == 1)
			reg_plan[REG_FILTER_ALPHA] = 16'd256;
		else if (pick == 2)
			reg_plan[REG_FILTER_ALPHA] = 16'($urandom_range(511, 257));
		else
			reg_plan[REG_FILTER_ALPHA] = 16'($urandom_range(255, 1));
		reg_plan[REG_ENABLE_DISTANCE] = 16'($urandom_range(600));
		reg_plan[REG_MIN_DISTANCE] = 16'($urandom_range(1000));
		on_angle = $urandom_range(5000, 300);
		reg_plan[REG_TURN_ON_ANGLE] = 16'(on_angle);
		reg_plan[REG_TURN_OFF_ANGLE] = 16'($urandom_range(on_angle + 200));
		reg_plan[REG_TARGET_DISTANCE] = 16'($urandom_range(3000, 300));
		reg_plan[REG_DISTANCE_DEADZONE] = 16'($urandom_range(600));
		if ($urandom_range(4) == 0)
			reg_plan[REG_HOLD_MS] = 16'($urandom_range(65535));
		else
			reg_plan[REG_HOLD_MS] = 16'($urandom_range(400));
	endtask

	task automatic queue_sample(input int range_val, input int ang, input logic [31:0] stamp);
		sensor_q.push_back('{range_val[15:0], ang[15:0], stamp});
	endtask

	// A target that drifts smoothly, so that the filters actually cross the thresholds,
	// with a share of arbitrary samples and clock jumps mixed in.
	task automatic queue_track(input int count);
		int unsigned pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				walk_clock = $urandom;
			else
				walk_clock += $urandom_range(150);
			if (pick < 10) begin
				queue_sample($urandom, $urandom, walk_clock);
			end else begin
				walk_dist += int'($urandom_range(600)) - 300;
				if (walk_dist < -100)
					walk_dist = -100;
				if (walk_dist > 6000)
					walk_dist = 6000;
				walk_ang += int'($urandom_range(2400)) - 1200;
				if (walk_ang < -8000)
					walk_ang = -8000;
				if (walk_ang > 8000)
					walk_ang = 8000;
				queue_sample(walk_dist, walk_ang, walk_clock);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: seeding, stop on non-positive distance, turns, hold and clock wrap.
		queue_sample(0, 0, 32'd0);
		queue_sample(-32768, 32767, 32'd5);
		queue_sample(-1, -32768, 32'd10);
		queue_sample(1200, 0, 32'd20);
		queue_sample(1200, 0, 32'd30);
		queue_sample(1200, 32767, 32'd40);
		queue_sample(1200, 32767, 32'd260);
		queue_sample(1200, -32768, 32'd300);
		queue_sample(1200, -32768, 32'd600);
		queue_sample(1200, -32768, 32'd700);
		queue_sample(1200, 0, 32'd1000);
		queue_sample(32767, 0, 32'hFFFF_FF00);
		queue_sample(32767, 32767, 32'h0000_0010);
		queue_sample(32767, -32768, 32'hFFFF_FFFF);
		queue_sample(5, 0, 32'd2000);
		queue_sample(5, 0, 32'd2100);
		queue_sample(5, 0, 32'd2200);
		queue_sample(5, 0, 32'd2300);
		queue_sample(1, 32767, 32'd2400);
		queue_sample(32767, 32767, 32'd2500);
		queue_sample(0, -1, 32'd2600);
		queue_sample(32767, -1, 32'd2700);

		// Every register at zero: frozen filters and no hold at all.
		foreach (reg_plan[i])
			reg_plan[i] = '0;
		apply_reg_plan();
		queue_track(60);

		// All ones: the top bits are dropped, alpha overshoots and thresholds sit at maximum.
		foreach (reg_plan[i])
			reg_plan[i] = '1;
		apply_reg_plan();
		queue_sample(32767, 32767, 32'd0);
		queue_sample(32767, -32768, 32'd1);
		queue_track(60);

		// Plain filter with full weight and a long hold.
		reg_plan[REG_FILTER_ALPHA] = 16'd256;
		reg_plan[REG_ENABLE_DISTANCE] = 16'd100;
		reg_plan[REG_MIN_DISTANCE] = 16'd300;
		reg_plan[REG_TURN_ON_ANGLE] = 16'd2000;
		reg_plan[REG_TURN_OFF_ANGLE] = 16'd800;
		reg_plan[REG_TARGET_DISTANCE] = 16'd1000;
		reg_plan[REG_DISTANCE_DEADZONE] = 16'd200;
		reg_plan[REG_HOLD_MS] = 16'd65535;
		apply_reg_plan();
		queue_track(60);

		for (int phase = 0; phase < 8; phase++) begin
			plan_random_regs();
			apply_reg_plan();
			if (phase == 3)
				steady = 1'b1;
			if (phase == 5) begin
				// The sender holds off until every command in flight has been returned.
				queue_track(100);
				wait_idle();
				queue_track(100);
			end else begin
				queue_track(200);
			end
			wait_idle();
			steady = 1'b0;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Covered %0d sensor transfers and %0d register writes over %0d settings.",
			items_sent, writes_done, settings_used);
		$display("Checked %0d commands (%0d stop, %0d forward, %0d left, %0d right), %0d errors.",
			cmds_checked, cmd_seen[DRV_HALT], cmd_seen[DRV_AHEAD], cmd_seen[DRV_LEFT],
			cmd_seen[DRV_RIGHT], fail_count);
		if (fail_count == 0)
			$display("follow_bang_bang_controller_unit_tb: PASS");
		else
			$display("follow_bang_bang_controller_unit_tb: FAIL");
		$finish;
	end

endmodule
